// ===== rtl/svag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svag_pkg
// Shared widths, register indexes and defaults for the strided view address
// generator.
// ----------------------------------------------------------------------------
package svag_pkg;

    localparam int DIMS_DEFAULT         = 4;
    localparam int OFFSET_WIDTH_DEFAULT = 48;

    localparam int IDX_W      = 48;
    localparam int SIZE_W     = 16;
    localparam int STRIDE_W   = 40;
    localparam int PROD_W     = SIZE_W + STRIDE_W;
    localparam int OUT_OFF_W  = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 40;

    localparam int NUM_SIZE_REGS    = 4;
    localparam int NUM_COORD_FIELDS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_BASE = CFG_IDX_W'(NUM_SIZE_REGS);

endpackage

// ===== rtl/svag_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svag_if
// Channel interfaces: index request, address result, register write.
// ----------------------------------------------------------------------------
interface svag_req_if;
    logic                       valid;
    logic                       ready;
    logic [svag_pkg::IDX_W-1:0] linear_index;

    modport source (output valid, output linear_index, input ready);
    modport sink   (input valid, input linear_index, output ready);
endinterface

interface svag_res_if;
    logic                           valid;
    logic                           ready;
    logic [svag_pkg::OUT_OFF_W-1:0] absolute_offset;
    logic [svag_pkg::SIZE_W-1:0]    coord_dim0;
    logic [svag_pkg::SIZE_W-1:0]    coord_dim1;
    logic [svag_pkg::SIZE_W-1:0]    coord_dim2;
    logic [svag_pkg::SIZE_W-1:0]    coord_dim3;

    modport source (output valid, output absolute_offset, output coord_dim0,
                    output coord_dim1, output coord_dim2, output coord_dim3,
                    input ready);
    modport sink   (input valid, input absolute_offset, input coord_dim0,
                    input coord_dim1, input coord_dim2, input coord_dim3,
                    output ready);
endinterface

interface svag_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [svag_pkg::CFG_IDX_W-1:0]  index;
    logic [svag_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/svag_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svag_div_cell
// One restoring-division bit step: shifts one dividend bit into the partial
// remainder and one quotient bit into the work word.
// ----------------------------------------------------------------------------
module svag_div_cell #(
    parameter int DIMS         = svag_pkg::DIMS_DEFAULT,
    parameter int OFFSET_WIDTH = svag_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic [svag_pkg::SIZE_W-1:0]             divisor,
    input  logic                                    in_valid,
    input  logic [svag_pkg::IDX_W-1:0]              in_work,
    input  logic [svag_pkg::SIZE_W-1:0]             in_rem,
    input  logic [DIMS-1:0][svag_pkg::SIZE_W-1:0]   in_coord,
    input  logic [OFFSET_WIDTH-1:0]                 in_offset,
    output logic                                    out_valid,
    output logic [svag_pkg::IDX_W-1:0]              out_work,
    output logic [svag_pkg::SIZE_W-1:0]             out_rem,
    output logic [DIMS-1:0][svag_pkg::SIZE_W-1:0]   out_coord,
    output logic [OFFSET_WIDTH-1:0]                 out_offset
);
    import svag_pkg::*;

    logic                  valid_reg;
    logic [IDX_W-1:0]      work_reg, work_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [DIMS-1:0][SIZE_W-1:0] coord_reg;
    logic [OFFSET_WIDTH-1:0]     offset_reg;
    logic [SIZE_W:0]       trial;
    logic [SIZE_W:0]       diff;
    logic                  ge;

    always_comb
    begin
        trial     = {in_rem, in_work[IDX_W-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        rem_next  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        work_next = {in_work[IDX_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg   <= work_next;
            rem_reg    <= rem_next;
            coord_reg  <= in_coord;
            offset_reg <= in_offset;
        end
    end

    assign out_valid  = valid_reg;
    assign out_work   = work_reg;
    assign out_rem    = rem_reg;
    assign out_coord  = coord_reg;
    assign out_offset = offset_reg;

endmodule

// ===== rtl/svag_mac_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svag_mac_cell
// Closes one dimension: latches the coordinate, multiplies it by the stride,
// then adds the product into the running offset. Two register stages.
// ----------------------------------------------------------------------------
module svag_mac_cell #(
    parameter int DIMS         = svag_pkg::DIMS_DEFAULT,
    parameter int OFFSET_WIDTH = svag_pkg::OFFSET_WIDTH_DEFAULT,
    parameter int DIM          = 0
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic [svag_pkg::STRIDE_W-1:0]           stride,
    input  logic                                    in_valid,
    input  logic [svag_pkg::IDX_W-1:0]              in_work,
    input  logic [svag_pkg::SIZE_W-1:0]             in_rem,
    input  logic [DIMS-1:0][svag_pkg::SIZE_W-1:0]   in_coord,
    input  logic [OFFSET_WIDTH-1:0]                 in_offset,
    output logic                                    out_valid,
    output logic [svag_pkg::IDX_W-1:0]              out_work,
    output logic [svag_pkg::SIZE_W-1:0]             out_rem,
    output logic [DIMS-1:0][svag_pkg::SIZE_W-1:0]   out_coord,
    output logic [OFFSET_WIDTH-1:0]                 out_offset
);
    import svag_pkg::*;

    logic                        mul_valid_reg;
    logic [IDX_W-1:0]            mul_work_reg;
    logic [DIMS-1:0][SIZE_W-1:0] mul_coord_reg, mul_coord_next;
    logic [OFFSET_WIDTH-1:0]     mul_offset_reg;
    logic [PROD_W-1:0]           prod_reg, prod_next;

    logic                        acc_valid_reg;
    logic [IDX_W-1:0]            acc_work_reg;
    logic [DIMS-1:0][SIZE_W-1:0] acc_coord_reg;
    logic [OFFSET_WIDTH-1:0]     acc_offset_reg, acc_offset_next;

    always_comb
    begin
        mul_coord_next      = in_coord;
        mul_coord_next[DIM] = in_rem;
        prod_next           = PROD_W'(in_rem) * PROD_W'(stride);
        acc_offset_next     = mul_offset_reg + OFFSET_WIDTH'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_valid;
            acc_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_work_reg   <= in_work;
            mul_coord_reg  <= mul_coord_next;
            mul_offset_reg <= in_offset;
            prod_reg       <= prod_next;
            acc_work_reg   <= mul_work_reg;
            acc_coord_reg  <= mul_coord_reg;
            acc_offset_reg <= acc_offset_next;
        end
    end

    assign out_valid  = acc_valid_reg;
    assign out_work   = acc_work_reg;
    assign out_rem    = '0;
    assign out_coord  = acc_coord_reg;
    assign out_offset = acc_offset_reg;

endmodule

// ===== rtl/strided_view_address_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_view_address_generator
// Splits a linear view index into per-dimension coordinates and the strided
// offset in parent storage.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle while the skid is empty; each
// dimension is a chain of 48 one-bit division cells followed by a
// multiply stage and an add stage.
// An output register and a one-entry skid hold results under backpressure.
// Reset: sizes 1, strides 0 except the innermost stride 1, pipeline empty.
module strided_view_address_generator #(
    parameter int DIMS         = svag_pkg::DIMS_DEFAULT,
    parameter int OFFSET_WIDTH = svag_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    svag_req_if.sink   request,
    svag_res_if.source result,
    svag_cfg_if.sink   cfg
);
    import svag_pkg::*;

    logic [DIMS-1:0][SIZE_W-1:0]   size_reg;
    logic [DIMS-1:0][SIZE_W-1:0]   size_eff;
    logic [DIMS-1:0][STRIDE_W-1:0] stride_reg;

    logic en;

    logic                        cv   [DIMS][IDX_W+1];
    logic [IDX_W-1:0]            cwork[DIMS][IDX_W+1];
    logic [SIZE_W-1:0]           crem [DIMS][IDX_W+1];
    logic [DIMS-1:0][SIZE_W-1:0] ccrd [DIMS][IDX_W+1];
    logic [OFFSET_WIDTH-1:0]     coff [DIMS][IDX_W+1];

    logic                        bv   [DIMS+1];
    logic [IDX_W-1:0]            bwork[DIMS+1];
    logic [SIZE_W-1:0]           brem [DIMS+1];
    logic [DIMS-1:0][SIZE_W-1:0] bcrd [DIMS+1];
    logic [OFFSET_WIDTH-1:0]     boff [DIMS+1];

    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    logic [OUT_OFF_W-1:0]        out_off_reg, skid_off_reg;
    logic [DIMS-1:0][SIZE_W-1:0] out_crd_reg, skid_crd_reg;

    assign cfg.ready = 1'b1;

    // configuration registers
    genvar gd, gk, gf;
    generate
        for (gd = 0; gd < DIMS; gd++)
        begin : g_cfg
            if (gd < NUM_SIZE_REGS)
            begin : g_wr
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        size_reg[gd]   <= SIZE_W'(1);
                        stride_reg[gd] <= (gd == DIMS-1) ? STRIDE_W'(1) : '0;
                    end
                    else if (cfg.valid && cfg.ready)
                    begin
                        if (cfg.index == CFG_SIZE_BASE + CFG_IDX_W'(gd))
                            size_reg[gd] <= cfg.data[SIZE_W-1:0];
                        if (cfg.index == CFG_STRIDE_BASE + CFG_IDX_W'(gd))
                            stride_reg[gd] <= cfg.data[STRIDE_W-1:0];
                    end
                end
            end
            else
            begin : g_fix
                assign size_reg[gd]   = SIZE_W'(1);
                assign stride_reg[gd] = (gd == DIMS-1) ? STRIDE_W'(1) : '0;
            end
            assign size_eff[gd] = (size_reg[gd] == '0) ? SIZE_W'(1) : size_reg[gd];
        end
    endgenerate

    // cell chain, innermost dimension first
    assign bv[0]    = request.valid && request.ready;
    assign bwork[0] = request.linear_index;
    assign brem[0]  = '0;
    assign bcrd[0]  = '0;
    assign boff[0]  = '0;

    generate
        for (gd = 0; gd < DIMS; gd++)
        begin : g_dim
            assign cv[gd][0]    = bv[gd];
            assign cwork[gd][0] = bwork[gd];
            assign crem[gd][0]  = brem[gd];
            assign ccrd[gd][0]  = bcrd[gd];
            assign coff[gd][0]  = boff[gd];

            for (gk = 0; gk < IDX_W; gk++)
            begin : g_bit
                svag_div_cell #(
                    .DIMS         (DIMS),
                    .OFFSET_WIDTH (OFFSET_WIDTH)
                ) u_div (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .en         (en),
                    .divisor    (size_eff[DIMS-1-gd]),
                    .in_valid   (cv[gd][gk]),
                    .in_work    (cwork[gd][gk]),
                    .in_rem     (crem[gd][gk]),
                    .in_coord   (ccrd[gd][gk]),
                    .in_offset  (coff[gd][gk]),
                    .out_valid  (cv[gd][gk+1]),
                    .out_work   (cwork[gd][gk+1]),
                    .out_rem    (crem[gd][gk+1]),
                    .out_coord  (ccrd[gd][gk+1]),
                    .out_offset (coff[gd][gk+1])
                );
            end

            svag_mac_cell #(
                .DIMS         (DIMS),
                .OFFSET_WIDTH (OFFSET_WIDTH),
                .DIM          (DIMS-1-gd)
            ) u_mac (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .stride     (stride_reg[DIMS-1-gd]),
                .in_valid   (cv[gd][IDX_W]),
                .in_work    (cwork[gd][IDX_W]),
                .in_rem     (crem[gd][IDX_W]),
                .in_coord   (ccrd[gd][IDX_W]),
                .in_offset  (coff[gd][IDX_W]),
                .out_valid  (bv[gd+1]),
                .out_work   (bwork[gd+1]),
                .out_rem    (brem[gd+1]),
                .out_coord  (bcrd[gd+1]),
                .out_offset (boff[gd+1])
            );
        end
    endgenerate

    // output register and skid
    assign en            = !skid_valid_reg;
    assign request.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (bv[DIMS])
            begin
                if (out_valid_reg && !result.ready)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (result.ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (bv[DIMS])
            begin
                if (out_valid_reg && !result.ready)
                begin
                    skid_off_reg <= OUT_OFF_W'(boff[DIMS]);
                    skid_crd_reg <= bcrd[DIMS];
                end
                else
                begin
                    out_off_reg <= OUT_OFF_W'(boff[DIMS]);
                    out_crd_reg <= bcrd[DIMS];
                end
            end
        end
        else if (result.ready)
        begin
            out_off_reg <= skid_off_reg;
            out_crd_reg <= skid_crd_reg;
        end
    end

    logic [NUM_COORD_FIELDS-1:0][SIZE_W-1:0] coord_field;

    generate
        for (gf = 0; gf < NUM_COORD_FIELDS; gf++)
        begin : g_fld
            if (gf < DIMS)
            begin : g_on
                assign coord_field[gf] = out_crd_reg[gf];
            end
            else
            begin : g_off
                assign coord_field[gf] = '0;
            end
        end
    endgenerate

    assign result.valid           = out_valid_reg;
    assign result.absolute_offset = out_off_reg;
    assign result.coord_dim0      = coord_field[0];
    assign result.coord_dim1      = coord_field[1];
    assign result.coord_dim2      = coord_field[2];
    assign result.coord_dim3      = coord_field[3];

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result.ready) |=> (skid_valid_reg && out_valid_reg))
        else $error("skid result lost under backpressure");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !request.ready)
        else $error("request taken while skid is full");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        size_eff[0] != '0 && size_eff[DIMS-1] != '0)
        else $error("zero divisor reached the division chain");

endmodule
